// ===== src/poly_voice_allocator_top_assert.svh =====
// assertion macros for the poly voice allocator
// expects signals clk and rst_n in the scope of each use
`ifndef POLY_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define PVA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pva check failed");
`define PVA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pva check failed");
`else
`define PVA_ASSERT_IMP(label, ante, cons)
`define PVA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== src/pva_pkg.sv =====
// shared constants, codes and types of the poly voice allocator
// no dependencies
`timescale 1ns / 1ps
package pva_pkg;

    localparam int VOICE_COUNT      = 8;
    localparam int STAMP_BITS       = 32;
    localparam int NOTE_COUNT       = 128;
    localparam int NOTE_BITS        = 7;
    localparam int VEL_BITS         = 7;
    localparam int VOICE_FIELD_BITS = 3;
    localparam int VIDX_BITS        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int SCAN_BITS        = $clog2(VOICE_COUNT + 1);

    // event operation codes
    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    // result kind codes
    localparam logic RES_START   = 1'b0;
    localparam logic RES_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_SCAN,
        S_STEAL,
        S_EMIT
    } pva_state_t;

    typedef struct packed {
        logic                        release_res;
        logic [VOICE_FIELD_BITS-1:0] voice;
        logic [NOTE_BITS-1:0]        voice_note;
        logic [VEL_BITS-1:0]         voice_velocity;
        logic                        retrigger;
        logic                        stolen;
        logic [NOTE_BITS-1:0]        stolen_note;
    } pva_res_t;

endpackage

// ===== src/pva_evt_if.sv =====
// note event channel: valid, ready and the event payload
// depends on pva_pkg
`timescale 1ns / 1ps
interface pva_evt_if
    import pva_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [NOTE_BITS-1:0] note;
    logic [VEL_BITS-1:0]  velocity;

    modport source (output valid, output operation, output note, output velocity,
                    input ready);
    modport sink   (input valid, input operation, input note, input velocity,
                    output ready);
endinterface

// ===== src/pva_res_if.sv =====
// voice result channel: valid, ready and the result payload
// depends on pva_pkg
`timescale 1ns / 1ps
interface pva_res_if
    import pva_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic                        release_res;
    logic [VOICE_FIELD_BITS-1:0] voice;
    logic [NOTE_BITS-1:0]        voice_note;
    logic [VEL_BITS-1:0]         voice_velocity;
    logic                        retrigger;
    logic                        stolen;
    logic [NOTE_BITS-1:0]        stolen_note;

    modport source (output valid, output release_res, output voice, output voice_note,
                    output voice_velocity, output retrigger, output stolen,
                    output stolen_note, input ready);
    modport sink   (input valid, input release_res, input voice, input voice_note,
                    input voice_velocity, input retrigger, input stolen,
                    input stolen_note, output ready);
endinterface

// ===== src/pva_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

// ===== src/poly_voice_allocator_top.sv =====
// poly voice allocator top: note-on/off events in, voice start/release beats out
// depends on pva_pkg, pva_evt_if, pva_res_if, pva_ram and the assertion header
// an event beat passes S_MAP and S_EMIT before its result is registered; a steal adds
//   S_SCAN and S_STEAL between them (a serial stamp scan, one stamp ram read per cycle);
//   a new event is taken only in S_IDLE, once the result is loaded or an unmapped note-off dropped
// reset (rst_n, async low) clears the note valid bits, busy flags, event counter and
//   control; the note map and stamp rams need no clearing pass
`timescale 1ns / 1ps
`include "poly_voice_allocator_top_assert.svh"
module poly_voice_allocator_top
    import pva_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    pva_evt_if.sink    evt,
    pva_res_if.source  res
);
    // control and bookkeeping registers
    pva_state_t state_reg, state_next;

    // one valid bit per note, voice index of the note lives in the map ram
    logic [NOTE_COUNT-1:0]  map_valid_reg, map_valid_next;
    logic [VOICE_COUNT-1:0] voice_busy_reg, voice_busy_next;
    // reverse map: note held by each busy voice, used to find the stolen note
    logic [NOTE_BITS-1:0]   voice_note_reg [VOICE_COUNT];
    logic [NOTE_BITS-1:0]   voice_note_next [VOICE_COUNT];
    logic [STAMP_BITS-1:0]  counter_reg, counter_next;

    // latched event
    logic                   op_reg, op_next;
    logic [NOTE_BITS-1:0]   note_reg, note_next;
    logic [VEL_BITS-1:0]    vel_reg, vel_next;

    // oldest-voice scan
    logic [SCAN_BITS-1:0]   issue_idx_reg, issue_idx_next;
    logic [VIDX_BITS-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [VIDX_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [STAMP_BITS-1:0]  best_stamp_reg, best_stamp_next;

    // result staging and output register
    pva_res_t               res_reg, res_next;
    pva_res_t               out_reg;
    logic                   out_valid_reg;
    logic                   out_load;

    // note map ram: note -> voice index
    logic                   map_we;
    logic [NOTE_BITS-1:0]   map_waddr;
    logic [VIDX_BITS-1:0]   map_wdata;
    logic                   map_re;
    logic [NOTE_BITS-1:0]   map_raddr;
    logic [VIDX_BITS-1:0]   map_rdata;

    // stamp ram: voice -> age stamp
    logic                   stamp_we;
    logic [VIDX_BITS-1:0]   stamp_waddr;
    logic [STAMP_BITS-1:0]  stamp_wdata;
    logic                   stamp_re;
    logic [VIDX_BITS-1:0]   stamp_raddr;
    logic [STAMP_BITS-1:0]  stamp_rdata;

    // derived
    logic [VIDX_BITS-1:0]   mapped_v;
    logic                   free_any;
    logic [VIDX_BITS-1:0]   free_idx;
    logic [NOTE_BITS-1:0]   lost_note;

    pva_ram #(
        .WIDTH (VIDX_BITS),
        .DEPTH (NOTE_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    pva_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (VOICE_COUNT)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (stamp_wdata),
        .re    (stamp_re),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    // out-of-range voice indexes fall back to voice 0
    assign mapped_v = ({1'b0, map_rdata} >= (VIDX_BITS + 1)'(VOICE_COUNT)) ? '0 : map_rdata;

    assign lost_note = voice_note_reg[best_idx_reg];

    // lowest free voice
    always_comb
    begin
        free_any = ~(&voice_busy_reg);
        free_idx = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (!voice_busy_reg[i])
            begin
                free_idx = VIDX_BITS'(i);
            end
        end
    end

    // no event beat is taken while reset is held
    assign evt.ready = rst_n && (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        map_valid_next  = map_valid_reg;
        voice_busy_next = voice_busy_reg;
        voice_note_next = voice_note_reg;
        counter_next    = counter_reg;
        op_next         = op_reg;
        note_next       = note_reg;
        vel_next        = vel_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        res_next        = res_reg;
        out_load        = 1'b0;
        map_we          = 1'b0;
        map_waddr       = note_reg;
        map_wdata       = '0;
        map_re          = 1'b0;
        map_raddr       = evt.note;
        stamp_we        = 1'b0;
        stamp_waddr     = '0;
        stamp_wdata     = counter_reg;
        stamp_re        = 1'b0;
        stamp_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    op_next    = evt.operation;
                    note_next  = evt.note;
                    vel_next   = evt.velocity;
                    map_re     = 1'b1;
                    state_next = S_MAP;
                end
            end

            S_MAP:
            begin
                priority if (op_reg == OP_NOTE_OFF)
                begin
                    if (!map_valid_reg[note_reg])
                    begin
                        // unmapped note-off: nothing to report
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        voice_busy_next[mapped_v] = 1'b0;
                        map_valid_next[note_reg]  = 1'b0;
                        res_next = '{release_res: RES_RELEASE,
                                     voice: VOICE_FIELD_BITS'(mapped_v),
                                     voice_note: note_reg,
                                     voice_velocity: '0,
                                     retrigger: 1'b0,
                                     stolen: 1'b0,
                                     stolen_note: '0};
                        state_next = S_EMIT;
                    end
                end
                else if (map_valid_reg[note_reg])
                begin
                    // held note: refresh its voice stamp
                    stamp_we     = 1'b1;
                    stamp_waddr  = mapped_v;
                    counter_next = counter_reg + STAMP_BITS'(1);
                    res_next = '{release_res: RES_START,
                                 voice: VOICE_FIELD_BITS'(mapped_v),
                                 voice_note: note_reg,
                                 voice_velocity: vel_reg,
                                 retrigger: 1'b1,
                                 stolen: 1'b0,
                                 stolen_note: '0};
                    state_next = S_EMIT;
                end
                else if (free_any)
                begin
                    voice_busy_next[free_idx] = 1'b1;
                    map_valid_next[note_reg]  = 1'b1;
                    voice_note_next[free_idx] = note_reg;
                    map_we       = 1'b1;
                    map_wdata    = free_idx;
                    stamp_we     = 1'b1;
                    stamp_waddr  = free_idx;
                    counter_next = counter_reg + STAMP_BITS'(1);
                    res_next = '{release_res: RES_START,
                                 voice: VOICE_FIELD_BITS'(free_idx),
                                 voice_note: note_reg,
                                 voice_velocity: vel_reg,
                                 retrigger: 1'b0,
                                 stolen: 1'b0,
                                 stolen_note: '0};
                    state_next = S_EMIT;
                end
                else
                begin
                    // all voices busy: start the stamp scan at voice 0
                    stamp_re       = 1'b1;
                    stamp_raddr    = '0;
                    issue_idx_next = SCAN_BITS'(1);
                    cmp_idx_next   = '0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // strict compare keeps the lowest index on ties
                if ((cmp_idx_reg == '0) || (stamp_rdata < best_stamp_reg))
                begin
                    best_stamp_next = stamp_rdata;
                    best_idx_next   = cmp_idx_reg;
                end
                if (issue_idx_reg < SCAN_BITS'(VOICE_COUNT))
                begin
                    stamp_re       = 1'b1;
                    stamp_raddr    = issue_idx_reg[VIDX_BITS-1:0];
                    cmp_idx_next   = issue_idx_reg[VIDX_BITS-1:0];
                    issue_idx_next = issue_idx_reg + SCAN_BITS'(1);
                end
                else
                begin
                    state_next = S_STEAL;
                end
            end

            S_STEAL:
            begin
                // unmap the old note first, then map the new one
                map_valid_next[lost_note]     = 1'b0;
                map_valid_next[note_reg]      = 1'b1;
                voice_busy_next[best_idx_reg] = 1'b1;
                voice_note_next[best_idx_reg] = note_reg;
                map_we       = 1'b1;
                map_wdata    = best_idx_reg;
                stamp_we     = 1'b1;
                stamp_waddr  = best_idx_reg;
                counter_next = counter_reg + STAMP_BITS'(1);
                res_next = '{release_res: RES_START,
                             voice: VOICE_FIELD_BITS'(best_idx_reg),
                             voice_note: note_reg,
                             voice_velocity: vel_reg,
                             retrigger: 1'b0,
                             stolen: 1'b1,
                             stolen_note: lost_note};
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            map_valid_reg  <= '0;
            voice_busy_reg <= '0;
            counter_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            map_valid_reg  <= map_valid_next;
            voice_busy_reg <= voice_busy_next;
            counter_reg    <= counter_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        voice_note_reg <= voice_note_next;
        op_reg         <= op_next;
        note_reg       <= note_next;
        vel_reg        <= vel_next;
        issue_idx_reg  <= issue_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        res_reg        <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.release_res    = out_reg.release_res;
    assign res.voice          = out_reg.voice;
    assign res.voice_note     = out_reg.voice_note;
    assign res.voice_velocity = out_reg.voice_velocity;
    assign res.retrigger      = out_reg.retrigger;
    assign res.stolen         = out_reg.stolen;
    assign res.stolen_note    = out_reg.stolen_note;

    // every busy voice owns exactly one mapped note
    `PVA_ASSERT_IMP(a_busy_matches_map, state_reg == S_IDLE, $countones(voice_busy_reg) == $countones(map_valid_reg))
    // stealing only happens with no free voice
    `PVA_ASSERT_IMP(a_steal_all_busy, state_reg == S_STEAL, &voice_busy_reg)
    // the voice being stolen still has its note mapped
    `PVA_ASSERT_IMP(a_stolen_note_mapped, state_reg == S_STEAL, map_valid_reg[lost_note])
    // a note-off never advances the event counter
    `PVA_ASSERT_NXT(a_off_keeps_counter, (state_reg == S_MAP) && (op_reg == OP_NOTE_OFF), $stable(counter_reg))
    // a steal advances the event counter by one
    `PVA_ASSERT_NXT(a_steal_bumps_counter, state_reg == S_STEAL, counter_reg == STAMP_BITS'($past(counter_reg) + 1'b1))

endmodule
